// ===== design/pvp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared widths, register indexes and limits for the vertex projection core.
// ----------------------------------------------------------------------------
package pvp_pkg;

   // scaled numerator width (magnitude times screen distance)
   localparam int M_W = 64;
   // view depth width used as divisor
   localparam int D_W = 48;
   // quotient bits: 16 integer bits plus one rounding bit
   localparam int DIV_BITS = 17;
   // register stages inside the divider
   localparam int DIV_LAT = DIV_BITS + 1;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_SIN_THETA       = 3'd0,
      CSR_COS_THETA       = 3'd1,
      CSR_SIN_PHI         = 3'd2,
      CSR_COS_PHI         = 3'd3,
      CSR_EYE_RADIUS      = 3'd4,
      CSR_SCREEN_DISTANCE = 3'd5
   } csr_index_type;

   // saturation limits
   localparam logic [15:0] SAT_POS = 16'h7fff;
   localparam logic [15:0] SAT_NEG = 16'h8000;
   localparam logic [16:0] LIM_POS = 17'd32767;
   localparam logic [16:0] LIM_NEG = 17'd32768;

   // per-beat sideband that rides beside the divider
   typedef struct packed {
      logic        valid;
      logic [23:0] color;
      logic        behind;
      logic        neg_x;
      logic        neg_y;
   } side_type;

endpackage

// ===== design/pvp_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvp_divider
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module pvp_divider (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [pvp_pkg::M_W-1:0]       m,
   input  logic [pvp_pkg::D_W-1:0]       d,
   output logic [pvp_pkg::DIV_BITS-1:0]  q2,
   output logic                          ovf
);

   localparam int N  = pvp_pkg::DIV_BITS;
   localparam int DW = pvp_pkg::D_W;
   localparam int MW = pvp_pkg::M_W;

   logic [DW-1:0] rem_ff [0:N];
   logic [DW-1:0] d_ff   [0:N];
   logic [N-1:0]  low_ff [0:N];
   logic [N-1:0]  q_ff   [0:N];
   logic          ovf_ff [0:N];

   logic          ovf0_in;

   // quotient of 2m/d must fit in N bits
   assign ovf0_in = (m[MW-1:N-1] >= d);

   // first stage: split dividend into running remainder and pending bits
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= ovf0_in ? '0 : m[MW-1:N-1];
         low_ff[0] <= {m[N-2:0], 1'b0};
         q_ff[0]   <= '0;
         d_ff[0]   <= d;
         ovf_ff[0] <= ovf0_in;
      end
   end

   // one compare and subtract per stage
   for (genvar i = 1; i <= N; i++) begin : g_step
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          fit;
      logic [DW-1:0] rem_in;

      assign trial  = {rem_ff[i-1], low_ff[i-1][N-1]};
      assign diff   = trial - {1'b0, d_ff[i-1]};
      assign fit    = (trial >= {1'b0, d_ff[i-1]});
      assign rem_in = fit ? diff[DW-1:0] : trial[DW-1:0];

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i] <= rem_in;
            low_ff[i] <= {low_ff[i-1][N-2:0], 1'b0};
            q_ff[i]   <= {q_ff[i-1][N-2:0], fit};
            d_ff[i]   <= d_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
         end
      end
   end

   assign q2  = q_ff[N];
   assign ovf = ovf_ff[N];

endmodule

// ===== design/perspective_vertex_projection_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_vertex_projection_core
// Rotates a world vertex into view space and projects it onto the screen.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one vertex per beat (x, y, z, color); rsp_* returns one
//   projected point per beat (screen x/y, color, behind-viewer flag).
//   A beat moves when valid is high and stall is low.
//   csr_* writes the six view registers; ready is always high. Write only
//   while no vertex is in flight.
// Pipeline: an accepted vertex passes through five stages of multiply and
//   sum, 18 divider stages (one quotient bit per stage, x and y in
//   parallel) and one output stage.
// Throughput: one vertex per cycle while the output is not stalled.
// Stall: the whole pipeline holds while a result waits under rsp_stall;
//   req_stall is then high, and nothing is lost or repeated.
// Reset: clears all valid bits and loads the default view registers.
// ----------------------------------------------------------------------------
module perspective_vertex_projection_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_vertex_x,
   input  logic signed [15:0] req_vertex_y,
   input  logic signed [15:0] req_vertex_z,
   input  logic [23:0]        req_color_tag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_screen_x,
   output logic signed [15:0] rsp_screen_y,
   output logic [23:0]        rsp_color_out,
   output logic               rsp_behind_viewer,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int DL = pvp_pkg::DIV_LAT;

   logic advance;

   // view registers
   logic signed [15:0] st_ff, ct_ff, sp_ff, cp_ff;
   logic [15:0]        eye_ff, dist_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= -16'sd16384;
         ct_ff   <= 16'sd0;
         sp_ff   <= 16'sd0;
         cp_ff   <= 16'sd16384;
         eye_ff  <= 16'd800;
         dist_ff <= 16'd1000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pvp_pkg::CSR_SIN_THETA:       st_ff   <= csr_wdata;
            pvp_pkg::CSR_COS_THETA:       ct_ff   <= csr_wdata;
            pvp_pkg::CSR_SIN_PHI:         sp_ff   <= csr_wdata;
            pvp_pkg::CSR_COS_PHI:         cp_ff   <= csr_wdata;
            pvp_pkg::CSR_EYE_RADIUS:      eye_ff  <= csr_wdata;
            pvp_pkg::CSR_SCREEN_DISTANCE: dist_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global pipeline enable
   assign req_stall = rsp_valid && rsp_stall;
   assign advance   = !req_stall;

   // stage 1: trig products and vertex-times-trig products
   logic               s1_valid_ff;
   logic [23:0]        s1_color_ff;
   logic signed [15:0] s1_x_ff, s1_y_ff;
   logic signed [31:0] s1_k5_ff, s1_k6_ff, s1_k7_ff, s1_k8_ff;
   logic signed [31:0] s1_stx_ff, s1_cty_ff, s1_spz_ff, s1_cpz_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (advance) s1_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_color_ff <= req_color_tag;
         s1_x_ff     <= req_vertex_x;
         s1_y_ff     <= req_vertex_y;
         s1_k5_ff    <= ct_ff * sp_ff;
         s1_k6_ff    <= st_ff * sp_ff;
         s1_k7_ff    <= ct_ff * cp_ff;
         s1_k8_ff    <= st_ff * cp_ff;
         s1_stx_ff   <= st_ff * req_vertex_x;
         s1_cty_ff   <= ct_ff * req_vertex_y;
         s1_spz_ff   <= sp_ff * req_vertex_z;
         s1_cpz_ff   <= cp_ff * req_vertex_z;
      end
   end

   // stage 2: second-level products, view x
   logic               s2_valid_ff;
   logic [23:0]        s2_color_ff;
   logic signed [47:0] s2_k5x_ff, s2_k6y_ff, s2_k7x_ff, s2_k8y_ff;
   logic signed [31:0] s2_spz_ff, s2_cpz_ff;
   logic signed [46:0] s2_vx_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (advance) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_color_ff <= s1_color_ff;
         s2_k5x_ff   <= s1_k5_ff * s1_x_ff;
         s2_k6y_ff   <= s1_k6_ff * s1_y_ff;
         s2_k7x_ff   <= s1_k7_ff * s1_x_ff;
         s2_k8y_ff   <= s1_k8_ff * s1_y_ff;
         s2_spz_ff   <= s1_spz_ff;
         s2_cpz_ff   <= s1_cpz_ff;
         s2_vx_ff    <= (47'(s1_cty_ff) - 47'(s1_stx_ff)) <<< 14;
      end
   end

   // stage 3: view y and view depth at scale 2^28
   logic               s3_valid_ff;
   logic [23:0]        s3_color_ff;
   logic signed [46:0] s3_vx_ff;
   logic signed [49:0] s3_vy_ff, s3_vz_ff;
   logic signed [49:0] eye_scaled;

   assign eye_scaled = $signed({6'd0, eye_ff, 28'd0});

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (advance) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_color_ff <= s2_color_ff;
         s3_vx_ff    <= s2_vx_ff;
         s3_vy_ff    <= (50'(s2_spz_ff) <<< 14) - 50'(s2_k7x_ff) - 50'(s2_k8y_ff);
         s3_vz_ff    <= eye_scaled - 50'(s2_k5x_ff) - 50'(s2_k6y_ff)
                        - (50'(s2_cpz_ff) <<< 14);
      end
   end

   // stage 4: sign and magnitude, depth check
   logic                      s4_valid_ff;
   logic [23:0]               s4_color_ff;
   logic                      s4_behind_ff, s4_neg_x_ff, s4_neg_y_ff;
   logic [47:0]               s4_mag_x_ff, s4_mag_y_ff;
   logic [pvp_pkg::D_W-1:0]   s4_d_ff;
   logic signed [47:0]        vx_ext;
   logic signed [49:0]        vy_neg;

   assign vx_ext = 48'(s3_vx_ff);
   assign vy_neg = -s3_vy_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (advance) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_color_ff  <= s3_color_ff;
         s4_behind_ff <= s3_vz_ff[49] || (s3_vz_ff == '0);
         s4_neg_x_ff  <= s3_vx_ff[46];
         s4_neg_y_ff  <= s3_vy_ff[49];
         s4_mag_x_ff  <= s3_vx_ff[46] ? 48'(-vx_ext) : 48'(vx_ext);
         s4_mag_y_ff  <= s3_vy_ff[49] ? vy_neg[47:0] : s3_vy_ff[47:0];
         s4_d_ff      <= s3_vz_ff[pvp_pkg::D_W-1:0];
      end
   end

   // stage 5: scale by screen distance
   pvp_pkg::side_type       s5_side_ff;
   logic [pvp_pkg::M_W-1:0] s5_mx_ff, s5_my_ff;
   logic [pvp_pkg::D_W-1:0] s5_d_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_side_ff.valid <= 1'b0;
      else if (advance) s5_side_ff.valid <= s4_valid_ff;
      if (advance) begin
         s5_side_ff.color  <= s4_color_ff;
         s5_side_ff.behind <= s4_behind_ff;
         s5_side_ff.neg_x  <= s4_neg_x_ff;
         s5_side_ff.neg_y  <= s4_neg_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_mx_ff <= 64'(s4_mag_x_ff) * 64'(dist_ff);
         s5_my_ff <= 64'(s4_mag_y_ff) * 64'(dist_ff);
         s5_d_ff  <= s4_d_ff;
      end
   end

   // dividers for x and y
   logic [pvp_pkg::DIV_BITS-1:0] qx2, qy2;
   logic                         ovf_x, ovf_y;

   pvp_divider u_div_x (
      .clock   (clock),
      .advance (advance),
      .m       (s5_mx_ff),
      .d       (s5_d_ff),
      .q2      (qx2),
      .ovf     (ovf_x)
   );

   pvp_divider u_div_y (
      .clock   (clock),
      .advance (advance),
      .m       (s5_my_ff),
      .d       (s5_d_ff),
      .q2      (qy2),
      .ovf     (ovf_y)
   );

   // sideband delay matching the divider
   pvp_pkg::side_type side_ff [0:DL-1];

   for (genvar i = 0; i < DL; i++) begin : g_side
      pvp_pkg::side_type side_in;
      if (i == 0) begin : g_first
         assign side_in = s5_side_ff;
      end else begin : g_next
         assign side_in = side_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) side_ff[i].valid <= 1'b0;
         else if (advance) side_ff[i].valid <= side_in.valid;
         if (advance) begin
            side_ff[i].color  <= side_in.color;
            side_ff[i].behind <= side_in.behind;
            side_ff[i].neg_x  <= side_in.neg_x;
            side_ff[i].neg_y  <= side_in.neg_y;
         end
      end
   end

   // add one half, truncate toward zero, saturate
   function automatic logic [15:0] round_sat(input logic [16:0] q2, input logic ovf,
                                             input logic neg);
      logic [15:0] q;
      logic [16:0] v;
      logic [15:0] r;
      q = q2[16:1];
      v = '0;
      if (!neg) begin
         v = {1'b0, q} + {16'd0, q2[0]};
         if (ovf || v > pvp_pkg::LIM_POS) r = pvp_pkg::SAT_POS;
         else r = v[15:0];
      end else if (ovf) begin
         r = pvp_pkg::SAT_NEG;
      end else if (q == '0) begin
         r = '0;
      end else begin
         v = {1'b0, q} - 17'd1 + {16'd0, q2[0]};
         if (v > pvp_pkg::LIM_NEG) r = pvp_pkg::SAT_NEG;
         else r = 16'(~v[15:0] + 16'd1);
      end
      return r;
   endfunction

   // output register
   pvp_pkg::side_type last_side;
   assign last_side = side_ff[DL-1];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (advance) rsp_valid <= last_side.valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_color_out     <= last_side.color;
         rsp_behind_viewer <= last_side.behind;
         rsp_screen_x      <= last_side.behind ? '0 : round_sat(qx2, ovf_x, last_side.neg_x);
         rsp_screen_y      <= last_side.behind ? '0 : round_sat(qy2, ovf_y, last_side.neg_y);
      end
   end

`ifndef SYNTHESIS
   // a point behind the viewer has zero coordinates
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_behind_viewer |-> rsp_screen_x == 0 && rsp_screen_y == 0)
      else $error("behind-viewer result with nonzero coordinates");

   // input is held back only by a waiting result
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the vertex projection core against its own projection predictor:
// directed corner vertices, random view angle sets and random vertex streams with
// bursty input and random output stalls, under several view register sets.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic [23:0]        color;
      logic               behind;
   } point_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_vertex_x;
   logic signed [15:0] req_vertex_y;
   logic signed [15:0] req_vertex_z;
   logic [23:0]        req_color_tag;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_screen_x;
   logic signed [15:0] rsp_screen_y;
   logic [23:0]        rsp_color_out;
   logic               rsp_behind_viewer;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;

   // view registers as the predictor sees them
   logic signed [15:0] v_st, v_ct, v_sp, v_cp;
   logic [15:0]        v_eye, v_dist;

   point_type points_due[$];
   int  mismatches;
   int  cycle_count;
   int  hold_cycles;
   int  holds_asked;
   int  holds_done;
   bit  bursty;

   perspective_vertex_projection_core dut (.*);

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // timeout guard
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // saturated projection of one view coordinate, add half then truncate
   function automatic logic [15:0] project_coord(longint num, longint den,
                                                 longint scale);
      logic [127:0] mag, m, q, r, v;
      logic [127:0] up;
      longint res;
      mag = (num < 0) ? -num : num;
      m = mag * scale;
      q = m / den;
      r = m % den;
      up = (2 * r >= den) ? 1 : 0;
      if (num >= 0) begin
         v = q + up;
         res = (v > 32767) ? 32767 : longint'(v);
      end else if (q == 0) begin
         res = 0;
      end else begin
         v = q - 1 + up;
         res = (v > 32768) ? -32768 : -longint'(v);
      end
      return res[15:0];
   endfunction

   function automatic point_type project_vertex(logic signed [15:0] x,
         logic signed [15:0] y, logic signed [15:0] z, logic [23:0] c);
      longint st, ct, sp, cp, vx, vy, vz;
      point_type p;
      st = v_st; ct = v_ct; sp = v_sp; cp = v_cp;
      vx = (-st * x + ct * y) * 16384;
      vy = -(ct * cp) * x - (st * cp) * y + sp * z * 16384;
      vz = -(ct * sp) * x - (st * sp) * y - cp * z * 16384
           + longint'(v_eye) * 268435456;
      p.color = c;
      if (vz <= 0) begin
         p.sx = 0; p.sy = 0; p.behind = 1;
      end else begin
         p.sx = project_coord(vx, vz, v_dist);
         p.sy = project_coord(vy, vz, v_dist);
         p.behind = 0;
      end
      return p;
   endfunction

   // result checker
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (points_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat x=%0d", rsp_screen_x);
         end else begin
            e = points_due.pop_front();
            if (e.sx !== rsp_screen_x || e.sy !== rsp_screen_y ||
                e.color !== rsp_color_out || e.behind !== rsp_behind_viewer) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp x=%0d y=%0d c=%h b=%b got x=%0d y=%0d c=%h b=%b",
                     e.sx, e.sy, e.color, e.behind, rsp_screen_x, rsp_screen_y,
                     rsp_color_out, rsp_behind_viewer);
            end
         end
      end
   end

   // receiver stall pattern, with long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         hold_cycles <= 0;
         holds_done <= holds_asked;
      end else if (holds_done != holds_asked) begin
         rsp_stall <= 1;
         hold_cycles <= 199;
         holds_done <= holds_asked;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles <= hold_cycles - 1;
      end else if (bursty) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= 0;
   end

   task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic [23:0] c);
      req_valid <= 1;
      req_vertex_x <= x;
      req_vertex_y <= y;
      req_vertex_z <= z;
      req_color_tag <= c;
      do @(posedge clock); while (req_stall);
      points_due.push_back(project_vertex(x, y, z, c));
      // gap between bursts
      if (bursty && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 0;
      while (points_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(pvp_pkg::csr_index_type idx, logic [15:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pvp_pkg::CSR_SIN_THETA:       v_st = d;
         pvp_pkg::CSR_COS_THETA:       v_ct = d;
         pvp_pkg::CSR_SIN_PHI:         v_sp = d;
         pvp_pkg::CSR_COS_PHI:         v_cp = d;
         pvp_pkg::CSR_EYE_RADIUS:      v_eye = d;
         pvp_pkg::CSR_SCREEN_DISTANCE: v_dist = d;
         default: ;
      endcase
   endtask

   task automatic write_view(int st, int ct, int sp, int cp, int eye, int plane);
      drain();
      write_csr(pvp_pkg::CSR_SIN_THETA, 16'(st));
      write_csr(pvp_pkg::CSR_COS_THETA, 16'(ct));
      write_csr(pvp_pkg::CSR_SIN_PHI, 16'(sp));
      write_csr(pvp_pkg::CSR_COS_PHI, 16'(cp));
      write_csr(pvp_pkg::CSR_EYE_RADIUS, 16'(eye));
      write_csr(pvp_pkg::CSR_SCREEN_DISTANCE, 16'(plane));
      csr_valid <= 0;
   endtask

   task automatic send_random(int n, int span);
      repeat (n) begin
         logic [15:0] x, y, z;
         x = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
         y = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
         z = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
         send_vertex(x, y, z, 24'($urandom));
      end
   endtask

   // corner vertices under reset view registers
   task automatic test_corners;
      send_vertex(0, 0, 0, 24'h000000);
      send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 24'hffffff);
      send_vertex(-16'sh8000, -16'sh8000, -16'sh8000, 24'h5a5a5a);
      send_vertex(16'sh7fff, -16'sh8000, 0, 24'ha5a5a5);
      send_vertex(1, 1, 800, 24'h123456);    // depth exactly zero
      send_vertex(40, -40, 799, 24'h654321); // tiny depth, saturates
      send_vertex(0, 0, 801, 24'h0f0f0f);    // behind the viewer
      send_vertex(2, -2, 0, 24'hf0f0f0);     // exact half on both signs
      send_vertex(-3, 7, 500, 24'h800001);
   endtask

   // extremes of the view registers, including values beyond unit range
   task automatic test_view_extremes;
      write_view(16384, 16384, 16384, 16384, 65535, 65535);
      send_random(20, 0);
      write_view(-16384, -16384, -16384, -16384, 0, 0);
      send_random(20, 0);
      write_view(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1, 65535);
      send_random(20, 300);
   endtask

   // random angle sets with bursty streams
   task automatic test_random_views;
      for (int i = 0; i < 8; i++) begin
         write_view($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 3000), $urandom);
         send_random(100, 2000);
         send_random(30, 0);
      end
   endtask

   // long output hold-off while input keeps offering
   task automatic test_backpressure;
      write_view(-11585, 11585, 8192, 14189, 1500, 900);
      holds_asked++;
      send_random(100, 1000);
      drain();
      bursty = 0;
      send_random(80, 1000);
      bursty = 1;
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_vertex_x = 0;
      req_vertex_y = 0;
      req_vertex_z = 0;
      req_color_tag = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_wdata = 0;
      mismatches = 0;
      holds_asked = 0;
      bursty = 1;
      v_st = -16384; v_ct = 0; v_sp = 0; v_cp = 16384; v_eye = 800; v_dist = 1000;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_corners();
      test_view_extremes();
      test_backpressure();
      test_random_views();
      drain();
      if (mismatches == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
